/* sv/keypad_scan_debounce_decode_unit_defines.svh */
// Assertion macros shared by the keypad scan debounce checker.
// No dependencies; every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef KEYPAD_SCAN_DEBOUNCE_DECODE_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_DECODE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KSDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KSDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ksdd_pkg.sv */
// Shared types, constants and key decode functions of the keypad scan debouncer.
// No dependencies; used by every module of the block.
package ksdd_pkg;

  localparam int unsigned ScanLines = 4;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned CntW      = 8;
  localparam int unsigned GroupW    = 3;

  localparam logic [CntW-1:0] ThrReset = 8'd4;
  localparam logic [CntW-1:0] CntMax   = 8'hFF;

  // Active-low sense codes.
  localparam logic [CodeW-1:0] CodeIdle = 4'hF;
  localparam logic [CodeW-1:0] CodeK0   = 4'hE;
  localparam logic [CodeW-1:0] CodeK1   = 4'hD;
  localparam logic [CodeW-1:0] CodeK2   = 4'hB;
  localparam logic [CodeW-1:0] CodeK3   = 4'h7;

  typedef logic [CodeW-1:0] code_t;
  typedef code_t [ScanLines-1:0] code_vec_t;

  // Control handed from the top level to every lane.
  typedef struct packed {
    logic            en;
    logic [CntW-1:0] thr;
  } lane_ctrl_t;

  // Flags produced by the merging stage.
  typedef struct packed {
    logic [GroupW-1:0] grp0;
    logic [GroupW-1:0] grp1;
    logic              grp3;
  } flags_t;

  // One result item.
  typedef struct packed {
    code_vec_t codes;
    flags_t    flags;
  } result_t;

  // Lines 0 and 1: set one bit, hold the group, or clear it.
  function automatic logic [GroupW-1:0] decode_group(logic [GroupW-1:0] flags, code_t code);
    logic [GroupW-1:0] res;
    unique case (code)
      CodeK0:  res = flags | 3'b001;
      CodeK1:  res = flags | 3'b010;
      CodeK2:  res = flags | 3'b100;
      CodeK3:  res = flags;
      default: res = '0;
    endcase
    return res;
  endfunction

  // Line 3: set the flag, hold it, or clear it.
  function automatic logic decode_line3(logic flag, code_t code);
    logic res;
    unique case (code) inside
      CodeK0:                 res = 1'b1;
      CodeK1, CodeK2, CodeK3: res = flag;
      default:                res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* sv/ksdd_lane.sv */
// One debounce lane: stored code and bounce counter of a single drive line.
// Depends on ksdd_pkg.
module ksdd_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ksdd_pkg::lane_ctrl_t ctrl_i,
  input  ksdd_pkg::code_t      sample_i,
  output ksdd_pkg::code_t      code_o
);

  ksdd_pkg::code_t             code_q, code_d;
  logic [ksdd_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [ksdd_pkg::CntW-1:0]   cnt_inc;

  always_comb begin
    cnt_inc = (cnt_q == ksdd_pkg::CntMax) ? cnt_q : cnt_q + ksdd_pkg::CntW'(1);
    code_d  = code_q;
    cnt_d   = '0;
    if (sample_i != code_q) begin
      if (cnt_inc > ctrl_i.thr) begin
        code_d = sample_i;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= ksdd_pkg::CodeIdle;
      cnt_q  <= '0;
    end else if (ctrl_i.en) begin
      code_q <= code_d;
      cnt_q  <= cnt_d;
    end
  end

  // The code this pass leaves behind, as the result reports it.
  assign code_o = code_d;

endmodule

/* sv/ksdd_merge.sv */
// Merging stage: turns the lanes' new codes into the sticky key flags.
// Depends on ksdd_pkg.
module ksdd_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  ksdd_pkg::code_vec_t codes_i,
  output ksdd_pkg::flags_t    flags_o
);

  ksdd_pkg::flags_t flags_q, flags_d;

  always_comb begin
    flags_d.grp0 = ksdd_pkg::decode_group(flags_q.grp0, codes_i[0]);
    flags_d.grp1 = ksdd_pkg::decode_group(flags_q.grp1, codes_i[1]);
    flags_d.grp3 = ksdd_pkg::decode_line3(flags_q.grp3, codes_i[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_d;

endmodule

/* sv/keypad_scan_debounce_decode_unit.sv */
// Top level of the 4x4 keypad scan debouncer and key decoder.
// Depends on ksdd_pkg, ksdd_lane and ksdd_merge.
//
// The block takes one full scan pass of a 4x4 key matrix per transfer: four
// active-low sense nibbles, one per drive line. Four debounce lanes work on the
// four lines side by side; each keeps a stable code and an 8-bit bounce counter,
// counting samples that differ from the stable code and adopting a sample once
// the count exceeds debounce_threshold (a matching sample clears the count, and
// the counter saturates at 255, so a threshold of 255 freezes the line). A
// merging stage then decodes the new codes of lines 0, 1 and 3 into sticky key
// flags; line 2 is debounced only. Every pass yields exactly one result. A new
// pass can be taken in every cycle unless the input stalls: all lane state
// updates in the accepting cycle, and the only loop is the compare and increment
// of each lane. The result goes to an output register backed by one skid entry,
// which takes it while the output stalls, so the input keeps flowing while a
// result waits; the input stalls only once both are full. The threshold
// register resets to 4 and is written through the configuration channel, which
// is always ready; write it only while the block is idle.
module keypad_scan_debounce_decode_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Scan pass input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  sense_line0_i,
  input  logic [3:0]  sense_line1_i,
  input  logic [3:0]  sense_line2_i,
  input  logic [3:0]  sense_line3_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  stable_code0_o,
  output logic [3:0]  stable_code1_o,
  output logic [3:0]  stable_code2_o,
  output logic [3:0]  stable_code3_o,
  output logic [2:0]  group0_flags_o,
  output logic [2:0]  group1_flags_o,
  output logic        group3_flag_o
);

  logic [ksdd_pkg::CntW-1:0] thr_q;
  logic                      in_xfer;
  ksdd_pkg::lane_ctrl_t      lane_ctrl;
  ksdd_pkg::code_vec_t       samples;
  ksdd_pkg::code_vec_t       new_codes;
  ksdd_pkg::flags_t          new_flags;
  ksdd_pkg::result_t         new_res;
  ksdd_pkg::result_t         out_q;
  ksdd_pkg::result_t         skid_q;
  logic                      out_valid_q;
  logic                      skid_valid_q;

  // The configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ksdd_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // The input stalls only while the skid entry holds a result.
  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign lane_ctrl.en  = in_xfer;
  assign lane_ctrl.thr = thr_q;

  assign samples[0] = sense_line0_i;
  assign samples[1] = sense_line1_i;
  assign samples[2] = sense_line2_i;
  assign samples[3] = sense_line3_i;

  // One debounce lane per drive line.
  for (genvar g = 0; g < ksdd_pkg::ScanLines; g++) begin : g_lane
    ksdd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (samples[g]),
      .code_o   (new_codes[g])
    );
  end

  // The merging stage decodes the lanes' new codes into the sticky flags.
  ksdd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_xfer),
    .codes_i (new_codes),
    .flags_o (new_flags)
  );

  assign new_res.codes = new_codes;
  assign new_res.flags = new_flags;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_xfer) begin
        out_q <= new_res;
      end
    end else if (in_xfer) begin
      skid_q <= new_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stable_code0_o = out_q.codes[0];
  assign stable_code1_o = out_q.codes[1];
  assign stable_code2_o = out_q.codes[2];
  assign stable_code3_o = out_q.codes[3];
  assign group0_flags_o = out_q.flags.grp0;
  assign group1_flags_o = out_q.flags.grp1;
  assign group3_flag_o  = out_q.flags.grp3;

endmodule

/* sv/ksdd_checker.sv */
// Port-level checker for the keypad scan debouncer, bound to the top level.
// Depends on keypad_scan_debounce_decode_unit_defines.svh and ksdd_pkg.
`include "keypad_scan_debounce_decode_unit_defines.svh"

module ksdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] stable_code0_o,
  input logic [3:0] stable_code1_o,
  input logic [3:0] stable_code2_o,
  input logic [3:0] stable_code3_o,
  input logic [2:0] group0_flags_o,
  input logic [2:0] group1_flags_o,
  input logic       group3_flag_o
);

  logic        out_busy;
  logic [22:0] out_bits;
  logic        line3_k0;
  logic        line1_k1;
  logic        line0_other;

  assign out_busy = out_valid_o && out_stall_i;
  assign out_bits = {stable_code3_o, stable_code2_o, stable_code1_o, stable_code0_o,
                     group0_flags_o, group1_flags_o, group3_flag_o};
  assign line3_k0 = out_valid_o && (stable_code3_o == ksdd_pkg::CodeK0);
  assign line1_k1 = out_valid_o && (stable_code1_o == ksdd_pkg::CodeK1);
  assign line0_other = out_valid_o &&
                       !(stable_code0_o inside {ksdd_pkg::CodeK0, ksdd_pkg::CodeK1,
                                                ksdd_pkg::CodeK2, ksdd_pkg::CodeK3});

  // A stalled result stays valid and unchanged.
  `KSDD_ASSERT_NEXT(a_out_hold, out_busy, out_valid_o && $stable(out_bits), "stalled result changed")

  // A stable 0xE on line 3 always comes with its flag set.
  `KSDD_ASSERT_NOW(a_grp3_set, line3_k0, group3_flag_o, "line 3 flag not set for its key")

  // A stable 0xD on line 1 always comes with flag bit 1 set.
  `KSDD_ASSERT_NOW(a_grp1_set, line1_k1, group1_flags_o[1], "line 1 flag bit 1 not set")

  // Any code on line 0 that is neither a key nor the hold code clears the group.
  `KSDD_ASSERT_NOW(a_grp0_clear, line0_other, group0_flags_o == 3'b000, "line 0 flags not cleared")

endmodule

bind keypad_scan_debounce_decode_unit ksdd_checker u_ksdd_checker (.*);

/* verif/tb.sv */
// Self-checking testbench of keypad_scan_debounce_decode_unit: a directed table,
// then random scans.
// Depends on ksdd_pkg and the block's RTL; expected results come from a predictor or the table.
`timescale 1ns / 1ps

module tb;

  // One result transfer: the four debounced codes and the sticky key flags.
  typedef struct packed {
    ksdd_pkg::code_vec_t         codes;
    logic [ksdd_pkg::GroupW-1:0] grp0;
    logic [ksdd_pkg::GroupW-1:0] grp1;
    logic                        grp3;
  } key_result_t;

  typedef enum logic {
    ROW_SCAN,
    ROW_CFG
  } row_kind_e;

  // A directed row either sends one scan pass or writes the threshold.
  // The sense vector reads line 3 down to line 0 in hex. Where typed is set,
  // the expected result is the one given in the row.
  typedef struct packed {
    row_kind_e           kind;
    logic [7:0]          thr;
    ksdd_pkg::code_vec_t sense;
    logic                typed;
    key_result_t         exp;
  } dir_row_t;

  localparam int NumDirRows = 20;
  localparam int NumPhases  = 6;
  localparam int DrainLimit = 20000;

  // Threshold starts at its reset value of 4.
  localparam dir_row_t DirRows [NumDirRows] = '{
    '{ROW_SCAN, 8'd0,   16'hFFFF, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b1, '{16'hFFFF, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b1, '{16'hE0DE, 3'd1, 3'd2, 1'b1}},
    '{ROW_SCAN, 8'd0,   16'hE0DB, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'hE0DE, 1'b0, '0},
    '{ROW_CFG,  8'd0,   16'h0000, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'h7F7B, 1'b1, '{16'h7F7B, 3'd5, 3'd2, 1'b1}},
    '{ROW_SCAN, 8'd0,   16'hB5ED, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'hDA70, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'h0F0F, 1'b0, '0},
    '{ROW_CFG,  8'd255, 16'h0000, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'hEEEE, 1'b1, '{16'h0F0F, 3'd0, 3'd0, 1'b0}},
    '{ROW_SCAN, 8'd0,   16'h0000, 1'b0, '0},
    '{ROW_CFG,  8'd254, 16'h0000, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'h1234, 1'b0, '0},
    '{ROW_CFG,  8'd4,   16'h0000, 1'b0, '0},
    '{ROW_SCAN, 8'd0,   16'hFFFF, 1'b0, '0}
  };

  // Random phases: threshold and number of scan passes. The last threshold
  // is replaced by a random one. The two large thresholds run long enough
  // for the bounce counter to saturate under 255 and to reach adoption under 254.
  localparam int PhaseThr   [NumPhases] = '{3, 0, 255, 1, 254, 9};
  localparam int PhaseItems [NumPhases] = '{300, 220, 300, 200, 540, 200};

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i    = 8'd0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [3:0] sense_line0_i = 4'hF;
  logic [3:0] sense_line1_i = 4'hF;
  logic [3:0] sense_line2_i = 4'hF;
  logic [3:0] sense_line3_i = 4'hF;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [3:0] stable_code0_o;
  logic [3:0] stable_code1_o;
  logic [3:0] stable_code2_o;
  logic [3:0] stable_code3_o;
  logic [2:0] group0_flags_o;
  logic [2:0] group1_flags_o;
  logic       group3_flag_o;

  // Predictor state: a copy of the block's debounce lanes and flags.
  ksdd_pkg::code_t             stable_q [ksdd_pkg::ScanLines];
  logic [ksdd_pkg::CntW-1:0]   bounce_q [ksdd_pkg::ScanLines];
  logic [ksdd_pkg::GroupW-1:0] grp0_q;
  logic [ksdd_pkg::GroupW-1:0] grp1_q;
  logic                        grp3_q;
  logic [ksdd_pkg::CntW-1:0]   thr_q;

  key_result_t pending_results [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 71;
  int mismatch_cnt  = 0;
  int fail_cnt      = 0;

  keypad_scan_debounce_decode_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sense_line0_i  (sense_line0_i),
    .sense_line1_i  (sense_line1_i),
    .sense_line2_i  (sense_line2_i),
    .sense_line3_i  (sense_line3_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stable_code0_o (stable_code0_o),
    .stable_code1_o (stable_code1_o),
    .stable_code2_o (stable_code2_o),
    .stable_code3_o (stable_code3_o),
    .group0_flags_o (group0_flags_o),
    .group1_flags_o (group1_flags_o),
    .group3_flag_o  (group3_flag_o)
  );

  always #2 clk_i = ~clk_i;

  // Next value of a line 0 or line 1 flag group: a key code sets its own bit,
  // the fourth key code leaves the group alone, and anything else wipes it.
  function automatic logic [ksdd_pkg::GroupW-1:0] next_group_flags(
    logic [ksdd_pkg::GroupW-1:0] flags,
    ksdd_pkg::code_t             code
  );
    if (code == ksdd_pkg::CodeK0) begin
      return flags | 3'b001;
    end else if (code == ksdd_pkg::CodeK1) begin
      return flags | 3'b010;
    end else if (code == ksdd_pkg::CodeK2) begin
      return flags | 3'b100;
    end else if (code == ksdd_pkg::CodeK3) begin
      return flags;
    end
    return 3'b000;
  endfunction

  // Advances the predictor by one scan pass and returns the result it implies.
  // All four lanes are debounced first; the flags are then decoded from the
  // new codes, so a sample that is adopted takes effect in the same pass.
  task automatic predict_scan(input ksdd_pkg::code_vec_t smp, output key_result_t res);
    for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
      if (smp[ln] != stable_q[ln]) begin
        // The counter sticks at its maximum, so a threshold of 255 never adopts.
        if (bounce_q[ln] != ksdd_pkg::CntMax) begin
          bounce_q[ln] = bounce_q[ln] + 1'b1;
        end
        if (bounce_q[ln] > thr_q) begin
          stable_q[ln] = smp[ln];
          bounce_q[ln] = '0;
        end
      end else begin
        bounce_q[ln] = '0;
      end
    end
    grp0_q = next_group_flags(grp0_q, stable_q[0]);
    grp1_q = next_group_flags(grp1_q, stable_q[1]);
    // Line 3 has a single flag: the first key sets it, the other three keep it.
    if (stable_q[3] == ksdd_pkg::CodeK0) begin
      grp3_q = 1'b1;
    end else if (stable_q[3] != ksdd_pkg::CodeK1 && stable_q[3] != ksdd_pkg::CodeK2 &&
                 stable_q[3] != ksdd_pkg::CodeK3) begin
      grp3_q = 1'b0;
    end
    for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
      res.codes[ln] = stable_q[ln];
    end
    res.grp0 = grp0_q;
    res.grp1 = grp1_q;
    res.grp3 = grp3_q;
  endtask

  // Sends one scan pass, after a random number of idle cycles, and queues the
  // expected result once the transfer has happened. The payload is held
  // unchanged for as long as the block stalls.
  task automatic scan_transfer(input ksdd_pkg::code_vec_t smp, input logic typed,
                               input key_result_t typed_exp);
    key_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sense_line0_i <= smp[0];
    sense_line1_i <= smp[1];
    sense_line2_i <= smp[2];
    sense_line3_i <= smp[3];
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_scan(smp, res);
    pending_results.push_back(typed ? typed_exp : res);
  endtask

  // Stops sending and waits until every queued result has come back, or DrainLimit is reached.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // Writes the threshold register; the caller makes sure the block is idle.
  task automatic write_threshold(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_q = value;
  endtask

  // Mostly the four key codes and the idle code, now and then any nibble.
  function automatic ksdd_pkg::code_t pick_key_code();
    case ($urandom_range(0, 9))
      0:       return ksdd_pkg::CodeK0;
      1:       return ksdd_pkg::CodeK1;
      2:       return ksdd_pkg::CodeK2;
      3:       return ksdd_pkg::CodeK3;
      4, 5:    return ksdd_pkg::CodeIdle;
      default: return ksdd_pkg::code_t'($urandom_range(0, 15));
    endcase
  endfunction

  // Random scans for one threshold setting. Most segments model a key held
  // steady long enough to be adopted (or just not quite), with the odd bounce
  // glitch mixed in; the rest are short bursts of pure noise. Large
  // thresholds get long segments and rarer glitches so that they adopt too.
  task automatic run_random_scans(input int n_items);
    ksdd_pkg::code_vec_t target;
    ksdd_pkg::code_vec_t smp;
    int                  seg_len;
    int                  glitch_div;
    int                  thr;
    int                  sent;
    logic                noisy;
    thr  = int'(thr_q);
    sent = 0;
    glitch_div = (thr >= 200) ? 64 : 12;
    while (sent < n_items) begin
      for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
        target[ln] = pick_key_code();
      end
      noisy = ($urandom_range(0, 4) == 0);
      if (noisy) begin
        seg_len = $urandom_range(1, 6);
      end else if (thr >= 200) begin
        seg_len = $urandom_range(thr - 2, thr + 12);
      end else begin
        seg_len = $urandom_range(1, thr + 4);
      end
      for (int k = 0; k < seg_len && sent < n_items; k++) begin
        for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
          if (noisy || $urandom_range(0, glitch_div - 1) == 0) begin
            smp[ln] = ksdd_pkg::code_t'($urandom_range(0, 15));
          end else begin
            smp[ln] = target[ln];
          end
        end
        scan_transfer(smp, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Compares one field of a result and reports the first few differences.
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, got_v);
      end
    end
  endtask

  // Result side: random stall, and a check of every result transfer against
  // the oldest expectation. Values are sampled before the edge updates them.
  always @(posedge clk_i) begin : result_check
    key_result_t got;
    key_result_t exp_res;
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.codes = {stable_code3_o, stable_code2_o, stable_code1_o, stable_code0_o};
      got.grp0  = group0_flags_o;
      got.grp1  = group1_flags_o;
      got.grp3  = group3_flag_o;
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("%0t: result transfer with nothing expected", $realtime);
        end
      end else begin
        exp_res = pending_results.pop_front();
        for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
          check_field($sformatf("stable_code%0d", ln), int'(exp_res.codes[ln]),
                      int'(got.codes[ln]));
        end
        check_field("group0_flags", int'(exp_res.grp0), int'(got.grp0));
        check_field("group1_flags", int'(exp_res.grp1), int'(got.grp1));
        check_field("group3_flag", int'(exp_res.grp3), int'(got.grp3));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final drain.
  initial begin : stimulus
    int thr_pick;
    for (int ln = 0; ln < ksdd_pkg::ScanLines; ln++) begin
      stable_q[ln] = ksdd_pkg::CodeIdle;
      bounce_q[ln] = '0;
    end
    grp0_q = '0;
    grp1_q = '0;
    grp3_q = 1'b0;
    thr_q  = ksdd_pkg::ThrReset;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the sender at 35 percent idle and the receiver at 71.
    for (int r = 0; r < NumDirRows; r++) begin
      if (DirRows[r].kind == ROW_CFG) begin
        wait_drained();
        write_threshold(DirRows[r].thr);
      end else begin
        scan_transfer(DirRows[r].sense, DirRows[r].typed, DirRows[r].exp);
      end
    end

    // Random part. The idle mix changes every two phases: first as above,
    // then the other way round, then no idling on either side. Before each
    // threshold write the sender holds off until every result is back.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 2) begin
        send_idle_pct = 71;
        recv_idle_pct = 35;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      thr_pick = (p == NumPhases - 1) ? $urandom_range(2, 12) : PhaseThr[p];
      wait_drained();
      write_threshold(8'(thr_pick));
      run_random_scans(PhaseItems[p]);
    end

    // Let the last results come out, then keep watching for strays.
    wait_drained();
    repeat (8) @(posedge clk_i);
    fail_cnt += pending_results.size();

    if (mismatch_cnt == 0 && fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
